>>> src/bdpc_pkg.sv
package bdpc_pkg;

  localparam int unsigned CNT_W = 32;
  localparam int unsigned CFG_W = 16;
  localparam int unsigned IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [IDX_W-1:0] REG_VERY_LONG    = 3'd3;
  localparam logic [IDX_W-1:0] REG_HELD_THRESH  = 3'd4;

  localparam logic             RST_ACTIVE_LEVEL = 1'b0;
  localparam logic [CFG_W-1:0] RST_DEBOUNCE     = 16'd20;
  localparam logic [CFG_W-1:0] RST_LONG_PRESS   = 16'd500;
  localparam logic [CFG_W-1:0] RST_VERY_LONG    = 16'd2000;
  localparam logic [CFG_W-1:0] RST_HELD_THRESH  = 16'd1000;

  localparam logic [1:0] EVT_NONE      = 2'd0;
  localparam logic [1:0] EVT_SHORT     = 2'd1;
  localparam logic [1:0] EVT_LONG      = 2'd2;
  localparam logic [1:0] EVT_VERY_LONG = 2'd3;

  typedef struct packed {
    logic             active_level;
    logic [CFG_W-1:0] debounce_ms;
    logic [CFG_W-1:0] long_press_ms;
    logic [CFG_W-1:0] very_long_press_ms;
    logic [CFG_W-1:0] held_threshold_ms;
  } cfg_t;

  typedef struct packed {
    logic             press_pulse;
    logic [1:0]       release_event;
    logic             is_pressed;
    logic [CNT_W-1:0] hold_duration_ms;
    logic             held_flag;
  } result_t;

endpackage

>>> src/bdpc_in_if.sv
interface bdpc_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

>>> src/bdpc_out_if.sv
interface bdpc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       press_pulse;
  logic [1:0]                 release_event;
  logic                       is_pressed;
  logic [bdpc_pkg::CNT_W-1:0] hold_duration_ms;
  logic                       held_flag;

  modport source (
    output valid, output press_pulse, output release_event, output is_pressed,
    output hold_duration_ms, output held_flag, input ready
  );
  modport sink (
    input valid, input press_pulse, input release_event, input is_pressed,
    input hold_duration_ms, input held_flag, output ready
  );
endinterface

>>> src/bdpc_cfg_if.sv
interface bdpc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [bdpc_pkg::IDX_W-1:0] index;
  logic [bdpc_pkg::CFG_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/bdpc_cfg_regs.sv
module bdpc_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [bdpc_pkg::IDX_W-1:0] wr_index,
  input  logic [bdpc_pkg::CFG_W-1:0] wr_data,
  output bdpc_pkg::cfg_t             cfg
);
  import bdpc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level       <= RST_ACTIVE_LEVEL;
      cfg.debounce_ms        <= RST_DEBOUNCE;
      cfg.long_press_ms      <= RST_LONG_PRESS;
      cfg.very_long_press_ms <= RST_VERY_LONG;
      cfg.held_threshold_ms  <= RST_HELD_THRESH;
    end else if (wr_en) begin
      case (wr_index)
        REG_ACTIVE_LEVEL: cfg.active_level       <= wr_data[0];
        REG_DEBOUNCE:     cfg.debounce_ms        <= wr_data;
        REG_LONG_PRESS:   cfg.long_press_ms      <= wr_data;
        REG_VERY_LONG:    cfg.very_long_press_ms <= wr_data;
        REG_HELD_THRESH:  cfg.held_threshold_ms  <= wr_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/bdpc_tracker.sv
module bdpc_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              pin_level,
  input  bdpc_pkg::cfg_t    cfg,
  output bdpc_pkg::result_t res
);
  import bdpc_pkg::*;

  logic             pressed_latch;
  logic [CNT_W-1:0] since_change_ms;
  logic [CNT_W-1:0] hold_count_ms;
  logic             pressed_latch_next;
  logic [CNT_W-1:0] since_change_ms_next;
  logic [CNT_W-1:0] hold_count_ms_next;

  logic             pin_pressed;
  logic [CNT_W-1:0] elapsed;
  logic [CNT_W-1:0] hold_inc;
  logic             may_change;
  logic             do_press;
  logic             do_release;
  logic [1:0]       event_code;
  logic [CNT_W-1:0] dur;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

  assign pin_pressed = (pin_level == cfg.active_level);
  assign elapsed     = sat_inc(since_change_ms);
  assign hold_inc    = sat_inc(hold_count_ms);
  assign may_change  = (elapsed >= {{(CNT_W-CFG_W){1'b0}}, cfg.debounce_ms});
  assign do_press    = pin_pressed && !pressed_latch && may_change;
  assign do_release  = !pin_pressed && pressed_latch && may_change;

  always_comb begin
    if (hold_inc >= {{(CNT_W-CFG_W){1'b0}}, cfg.very_long_press_ms}) begin
      event_code = EVT_VERY_LONG;
    end else if (hold_inc >= {{(CNT_W-CFG_W){1'b0}}, cfg.long_press_ms}) begin
      event_code = EVT_LONG;
    end else begin
      event_code = EVT_SHORT;
    end
  end

  always_comb begin
    pressed_latch_next   = pressed_latch;
    since_change_ms_next = elapsed;
    hold_count_ms_next   = pressed_latch ? hold_inc : hold_count_ms;
    if (do_press) begin
      pressed_latch_next   = 1'b1;
      since_change_ms_next = '0;
      hold_count_ms_next   = '0;
    end else if (do_release) begin
      pressed_latch_next   = 1'b0;
      since_change_ms_next = '0;
      hold_count_ms_next   = '0;
    end
  end

  assign dur = pressed_latch_next ? hold_count_ms_next : '0;

  always_comb begin
    res.press_pulse      = do_press;
    res.release_event    = do_release ? event_code : EVT_NONE;
    res.is_pressed       = pressed_latch_next;
    res.hold_duration_ms = dur;
    res.held_flag        = pressed_latch_next &&
                           (dur >= {{(CNT_W-CFG_W){1'b0}}, cfg.held_threshold_ms});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_latch   <= 1'b0;
      since_change_ms <= '0;
      hold_count_ms   <= '0;
    end else if (step) begin
      pressed_latch   <= pressed_latch_next;
      since_change_ms <= since_change_ms_next;
      hold_count_ms   <= hold_count_ms_next;
    end
  end

endmodule

>>> src/button_debounce_press_classifier.sv
// Button debouncer with press pulse and release classification.
// tick:   one transaction per millisecond tick, carrying the raw pin level.
// result: one transaction for every tick, in order: press pulse, release
//         class (none, short, long, very long), debounced state, saturating
//         hold duration and held flag.
// cfg:    register writes (active level, debounce, long, very long and held
//         thresholds); always ready, to be written only while the block is idle.
// A tick is taken into an input register and, when the result register can
// advance, evaluated against the debounce state and written into the result
// register, from which its result is offered.
// Throughput is one tick per cycle while results are taken, bounded by the
// combinational update of the saturating counters and threshold compares.
// When the receiver stalls, the result register holds and one further tick
// is still taken into the input register; then tick.ready drops.
// Synchronous reset releases the latch, clears both counters, restores the
// register defaults and empties both pipeline registers.
module button_debounce_press_classifier (
  input logic        clk,
  input logic        rst,
  bdpc_in_if.sink    tick,
  bdpc_out_if.source result,
  bdpc_cfg_if.sink   cfg
);
  import bdpc_pkg::*;

  cfg_t    cfg_q;
  result_t res_next;
  result_t res_q;
  logic    s1_valid;
  logic    pin_q;
  logic    out_valid;
  logic    out_adv;
  logic    step;

  assign out_adv    = !out_valid || result.ready;
  assign step       = s1_valid && out_adv;
  assign tick.ready = !s1_valid || out_adv;
  assign cfg.ready  = 1'b1;

  bdpc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_q)
  );

  bdpc_tracker u_tracker (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .pin_level (pin_q),
    .cfg       (cfg_q),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      pin_q <= tick.pin_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_q <= res_next;
    end
  end

  assign result.valid            = out_valid;
  assign result.press_pulse      = res_q.press_pulse;
  assign result.release_event    = res_q.release_event;
  assign result.is_pressed       = res_q.is_pressed;
  assign result.hold_duration_ms = res_q.hold_duration_ms;
  assign result.held_flag        = res_q.held_flag;

  // A press and a release can never be reported in the same transaction.
  a_press_xor_release: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.press_pulse && result.release_event != EVT_NONE))
    else $error("press and release reported together");

  // A release always leaves the block in the released state with no hold time.
  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.release_event != EVT_NONE) |->
      (!result.is_pressed && result.hold_duration_ms == '0 && !result.held_flag))
    else $error("release did not clear the hold state");

  // A press restarts the hold count and latches the pressed state.
  a_press_restarts: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.press_pulse) |->
      (result.is_pressed && result.hold_duration_ms == '0))
    else $error("press did not restart the hold count");

  // The tracker state only moves when a tick leaves the input register.
  a_step_needs_item: assert property (@(posedge clk) disable iff (rst)
    step |-> $past(tick.valid && tick.ready) || $past(s1_valid))
    else $error("state advanced without a pending tick");

endmodule
